// ===== src/u2cc_pkg.sv =====
// ----------------------------------------------------------------------------
// u2cc_pkg
// Shared types and decode/mapping functions for the UTF-8 to character
// code decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u2cc_pkg;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [7:0]  SUBST_RESET    = 8'd63;

    typedef struct packed {
        logic [20:0] code_point;
        logic        malformed;
        logic [2:0]  bytes_used;
    } t_decoded;

    typedef struct packed {
        t_decoded dec;
        logic     end_of_run;
    } t_result;

    // Sequence length from a lead byte, 0 for an invalid lead.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    // Decode one sequence starting at b0, with avail bytes present.
    function automatic t_decoded decode_at(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [2:0] avail);
        logic [2:0] len;
        t_decoded   d;
        len          = lead_length(b0);
        d.malformed  = 1'b0;
        d.bytes_used = len;
        case (len)
            3'd1: begin
                d.code_point = {13'b0, b0};
            end
            3'd2: begin
                d.code_point = {10'b0, b0[4:0], b1[5:0]};
            end
            3'd3: begin
                d.code_point = {5'b0, b0[3:0], b1[5:0], b2[5:0]};
            end
            3'd4: begin
                d.code_point = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            end
            default: begin
                d.code_point = CP_REPLACEMENT;
                d.malformed  = 1'b1;
                d.bytes_used = 3'd1;
            end
        endcase
        // truncated sequence: lead alone gives the replacement
        if (len > 3'd1 && avail < len) begin
            d.code_point = CP_REPLACEMENT;
            d.malformed  = 1'b1;
            d.bytes_used = 3'd1;
        end
        return d;
    endfunction

    // Code point to home-computer character code.
    function automatic logic [7:0] map_code(input logic [20:0] cp, input logic [7:0] subst);
        logic [7:0] code;
        code = subst;
        if (cp[20:16] != 5'd0) begin
            code = subst;
        end else if (cp[15:0] <= 16'h005F) begin
            code = cp[7:0];
        end else if (cp[15:0] inside {[16'h0061:16'h007A]}) begin
            code = cp[7:0] - 8'h20;
        end else begin
            case (cp[15:0])
                16'h00A5: code = 8'd92;
                16'h30A2: code = 8'd96;  16'h30A4: code = 8'd97;  16'h30A6: code = 8'd98;
                16'h30A8: code = 8'd99;  16'h30AA: code = 8'd100; 16'h30AB: code = 8'd101;
                16'h30AD: code = 8'd102; 16'h30AF: code = 8'd103; 16'h30B1: code = 8'd104;
                16'h30B3: code = 8'd105; 16'h30B5: code = 8'd106; 16'h30B7: code = 8'd107;
                16'h30B9: code = 8'd108; 16'h30BB: code = 8'd109; 16'h30BD: code = 8'd110;
                16'h30BF: code = 8'd111; 16'h30C1: code = 8'd112; 16'h30C4: code = 8'd113;
                16'h30C6: code = 8'd114; 16'h30C8: code = 8'd115; 16'h30CA: code = 8'd116;
                16'h30CB: code = 8'd117; 16'h30CC: code = 8'd118; 16'h30CD: code = 8'd119;
                16'h30CE: code = 8'd120; 16'h30CF: code = 8'd121; 16'h30D2: code = 8'd122;
                16'h30D5: code = 8'd123; 16'h30D8: code = 8'd124; 16'h30DB: code = 8'd125;
                16'h30DE: code = 8'd126; 16'h30DF: code = 8'd127;
                16'h30E0: code = 8'd128; 16'h30E1: code = 8'd129; 16'h30E2: code = 8'd130;
                16'h30E4: code = 8'd131; 16'h30E6: code = 8'd132; 16'h30E8: code = 8'd133;
                16'h30E9: code = 8'd134; 16'h30EA: code = 8'd135; 16'h30EB: code = 8'd136;
                16'h30EC: code = 8'd137; 16'h30ED: code = 8'd138; 16'h30EF: code = 8'd139;
                16'h30F3: code = 8'd140; 16'h30F2: code = 8'd141;
                16'h30A1: code = 8'd142; 16'h30A3: code = 8'd143; 16'h30A5: code = 8'd144;
                16'h30A7: code = 8'd145; 16'h30A9: code = 8'd146; 16'h30E3: code = 8'd147;
                16'h30E5: code = 8'd148; 16'h30E7: code = 8'd149; 16'h30C3: code = 8'd150;
                16'h30AC: code = 8'd151; 16'h30AE: code = 8'd152; 16'h30B0: code = 8'd153;
                16'h30B2: code = 8'd154; 16'h30B4: code = 8'd155; 16'h30B6: code = 8'd156;
                16'h30B8: code = 8'd157; 16'h30BA: code = 8'd158; 16'h30BC: code = 8'd159;
                16'h30BE: code = 8'd160; 16'h30C0: code = 8'd161; 16'h30C2: code = 8'd162;
                16'h30C5: code = 8'd163; 16'h30C7: code = 8'd164; 16'h30C9: code = 8'd165;
                16'h30D0: code = 8'd166; 16'h30D3: code = 8'd167; 16'h30D6: code = 8'd168;
                16'h30D9: code = 8'd169; 16'h30DC: code = 8'd170; 16'h30D1: code = 8'd171;
                16'h30D4: code = 8'd172; 16'h30D7: code = 8'd173; 16'h30DA: code = 8'd174;
                16'h30DD: code = 8'd175;
                16'h00B0: code = 8'd177; 16'h300C: code = 8'd178; 16'h300D: code = 8'd179;
                16'h00A9: code = 8'd180; 16'h00D7: code = 8'd181; 16'h00F7: code = 8'd182;
                default:  code = subst;
            endcase
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== src/u2cc_seq.sv =====
// ----------------------------------------------------------------------------
// u2cc_seq
// Input register, held-sequence state and result sequencing. Emits up to
// three decoded results per input byte, one per cycle while the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module u2cc_seq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire [7:0]            i_byte_in,
    input  wire                  i_stream_end,
    output logic                 o_in_stall,
    input  wire                  i_out_free,
    output logic                 o_res_valid,
    output u2cc_pkg::t_result    o_res
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic [7:0] r_pend [3];
    logic [1:0] r_count;
    logic [1:0] r_idx;

    logic [7:0] s0, s1, s2, s3;
    logic [2:0] avail;
    logic [2:0] lead_len;
    logic [1:0] num_res;
    logic       more1, more2;
    logic       last;
    logic       consume;
    logic       accept;
    logic       hold_seq;
    logic [1:0] n_idx;
    u2cc_pkg::t_decoded d0, d1, d2;

    always_comb begin
        s0 = (r_count == 2'd0) ? r_byte : r_pend[0];
        s1 = (r_count == 2'd1) ? r_byte : ((r_count > 2'd1) ? r_pend[1] : 8'h00);
        s2 = (r_count == 2'd2) ? r_byte : ((r_count == 2'd3) ? r_pend[2] : 8'h00);
        s3 = (r_count == 2'd3) ? r_byte : 8'h00;
        avail    = {1'b0, r_count} + 3'd1;
        lead_len = u2cc_pkg::lead_length(s0);
        d0 = u2cc_pkg::decode_at(s0, s1, s2, s3, avail);
        d1 = u2cc_pkg::decode_at(s1, s2, s3, 8'h00, avail - 3'd1);
        d2 = u2cc_pkg::decode_at(s2, s3, 8'h00, 8'h00, avail - 3'd2);

        // on stream end, leftover bytes after a broken lead decode as fresh leads
        more1 = (d0.bytes_used == 3'd1) && (avail > 3'd1);
        more2 = more1 && (d1.bytes_used == 3'd1) && (avail > 3'd2);
        hold_seq = !r_end && (lead_len > 3'd1) && (avail < lead_len);
        if (r_end) begin
            num_res = 2'd1 + {1'b0, more1} + {1'b0, more2};
        end else begin
            num_res = hold_seq ? 2'd0 : 2'd1;
        end

        last    = (r_idx == num_res - 2'd1);
        consume = r_in_valid && ((num_res == 2'd0) || (i_out_free && last));
        n_idx   = last ? 2'd0 : r_idx + 2'd1;
    end

    assign o_in_stall  = r_in_valid && !consume;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_res_valid = r_in_valid && (num_res != 2'd0);

    always_comb begin
        case (r_idx)
            2'd0:    o_res.dec = d0;
            2'd1:    o_res.dec = d1;
            default: o_res.dec = d2;
        endcase
        o_res.end_of_run = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_count    <= 2'd0;
            r_idx      <= 2'd0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (o_res_valid && i_out_free) begin
                r_idx <= n_idx;
            end
            if (consume) begin
                r_count <= hold_seq ? avail[1:0] : 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_byte_in;
            r_end  <= i_stream_end;
        end
        // hold the byte of an unfinished sequence
        if (consume && hold_seq) begin
            r_pend[r_count] <= r_byte;
        end
    end

endmodule

`default_nettype wire

// ===== src/u2cc_out.sv =====
// ----------------------------------------------------------------------------
// u2cc_out
// Character mapping and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module u2cc_out (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_res_valid,
    input  wire u2cc_pkg::t_result i_res,
    input  wire [7:0]            i_subst,
    output logic                 o_out_free,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic [7:0]           o_char_code,
    output logic [20:0]          o_code_point,
    output logic                 o_malformed,
    output logic [2:0]           o_bytes_used,
    output logic                 o_end_of_run
);

    logic        r_valid;
    logic [7:0]  r_char_code;
    logic [20:0] r_code_point;
    logic        r_malformed;
    logic [2:0]  r_bytes_used;
    logic        r_end_of_run;

    assign o_out_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_out_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out_free && i_res_valid) begin
            r_char_code  <= u2cc_pkg::map_code(i_res.dec.code_point, i_subst);
            r_code_point <= i_res.dec.code_point;
            r_malformed  <= i_res.dec.malformed;
            r_bytes_used <= i_res.dec.bytes_used;
            r_end_of_run <= i_res.end_of_run;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_char_code  = r_char_code;
    assign o_code_point = r_code_point;
    assign o_malformed  = r_malformed;
    assign o_bytes_used = r_bytes_used;
    assign o_end_of_run = r_end_of_run;

endmodule

`default_nettype wire

// ===== src/utf8_to_charset_code_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_charset_code_decoder
// UTF-8 byte stream to code point and 8-bit character code.
// ----------------------------------------------------------------------------
// Bytes enter at one per cycle unless stalled and land in an input register;
// decode and table lookup sit between it and the result register. A byte
// that finishes a sequence gives one result, a byte inside a sequence gives
// none. A final byte (stream_end) that breaks a held sequence gives up to
// three results, one per cycle from the result register unless stalled, and
// the input stalls until the last of them is taken. The result register lets
// a new byte in while a finished result waits to be taken.
// The substitute code register may be written at any time the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_charset_code_decoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire [7:0]   i_byte_in,
    input  wire         i_stream_end,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [7:0]  o_char_code,
    output logic [20:0] o_code_point,
    output logic        o_malformed,
    output logic [2:0]  o_bytes_used,
    output logic        o_end_of_run,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [7:0]   i_cfg_data
);

    logic [7:0]        r_subst;
    logic              res_valid;
    logic              out_free;
    u2cc_pkg::t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subst <= u2cc_pkg::SUBST_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_subst <= i_cfg_data;
        end
    end

    u2cc_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_byte_in    (i_byte_in),
        .i_stream_end (i_stream_end),
        .o_in_stall   (o_in_stall),
        .i_out_free   (out_free),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    u2cc_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res_valid  (res_valid),
        .i_res        (res),
        .i_subst      (r_subst),
        .o_out_free   (out_free),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_char_code  (o_char_code),
        .o_code_point (o_code_point),
        .o_malformed  (o_malformed),
        .o_bytes_used (o_bytes_used),
        .o_end_of_run (o_end_of_run)
    );

endmodule

`default_nettype wire
